// File: sv/acpe_pkg.sv
// Shared types and constants of the autocorrelation peak period estimator.
// No dependencies; every other file of the block imports this package.
package acpe_pkg;

    localparam int VALUE_W = 16;
    localparam int COUNT_W = 10;
    localparam int SUM_W   = 25;
    localparam int MAX_W   = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic signed [VALUE_W-1:0] BOUND_RESET = 16'sd8192;
    localparam logic signed [VALUE_W-1:0] AVG_POS_MAX = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] AVG_NEG_MAX = 16'sh8000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] corr_value;
        logic                      last_lag;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]        period;
        logic                      period_valid;
        logic signed [VALUE_W-1:0] average_peak;
        logic                      average_valid;
        logic [MAX_W-1:0]          highest_peak;
        logic [COUNT_W-1:0]        peak_count;
        logic [COUNT_W-1:0]        strong_peak_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_PER_START,
        ST_PER_WAIT,
        ST_PUBLISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic div_start;
        logic div_sel_period;
        logic capture_avg;
        logic capture_period;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_full;
    } status_t;

endpackage

// File: sv/acpe_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on acpe_pkg for the dividend and divisor widths.
module acpe_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [acpe_pkg::SUM_W-1:0]   dividend,
    input  logic [acpe_pkg::COUNT_W-1:0] divisor,
    output logic                         done,
    output logic [acpe_pkg::SUM_W-1:0]   quotient
);
    import acpe_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W-1:0]  divisor_reg, divisor_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [COUNT_W:0]    trial;
    logic [COUNT_W:0]    trial_diff;
    logic                fits;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[SUM_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        fits       = (trial >= {1'b0, divisor_reg});

        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;

        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            divisor_next = divisor;
            quo_next     = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/acpe_datapath.sv
// Datapath: peak detection, accumulators, shared divider and output register.
// Depends on acpe_pkg and acpe_divider.
module acpe_datapath #(
    parameter int MAX_LAGS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  acpe_pkg::cmd_t                    cmd,
    output acpe_pkg::status_t                 status,
    input  acpe_pkg::in_item_t                in_data,
    input  logic                              cfg_write_en,
    input  logic signed [acpe_pkg::VALUE_W-1:0] cfg_write_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output acpe_pkg::out_item_t               out_data
);
    import acpe_pkg::*;

    localparam int LAG_W = $clog2(MAX_LAGS);
    localparam logic [LAG_W-1:0] LAG_LAST = LAG_W'(MAX_LAGS - 1);
    localparam logic [LAG_W-1:0] LAG_TWO  = LAG_W'(2);

    logic signed [VALUE_W-1:0] bound_reg;
    logic signed [VALUE_W-1:0] older_reg, older_next;
    logic signed [VALUE_W-1:0] newer_reg, newer_next;
    logic [LAG_W-1:0]          lag_reg, lag_next;
    logic [LAG_W-1:0]          first_reg, first_next;
    logic [LAG_W-1:0]          last_reg, last_next;
    logic [COUNT_W-1:0]        strong_reg, strong_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [MAX_W-1:0]          max_reg, max_next;
    logic signed [VALUE_W-1:0] avg_reg;
    logic [COUNT_W-1:0]        per_reg;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg;

    logic                      is_peak;
    logic                      is_strong;
    logic [LAG_W-1:0]          middle_lag;
    logic signed [SUM_W:0]     sum_wide;

    logic [SUM_W-1:0]          sum_mag;
    logic                      sum_neg;
    logic [LAG_W-1:0]          span;
    logic [SUM_W-1:0]          div_dividend;
    logic [COUNT_W-1:0]        div_divisor;
    logic                      div_done;
    logic [SUM_W-1:0]          div_quotient;
    logic signed [VALUE_W-1:0] avg_value;
    logic [COUNT_W-1:0]        per_value;
    logic                      have_peaks;
    logic                      have_period;

    // Per-lag update: the middle value of the window is a peak when it is
    // strictly above both neighbors and at least two lags precede the new one.
    always_comb
    begin
        is_peak    = (lag_reg >= LAG_TWO) && (older_reg < newer_reg)
                     && (newer_reg > in_data.corr_value);
        is_strong  = newer_reg > bound_reg;
        middle_lag = lag_reg - 1'b1;
        sum_wide   = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(newer_reg);

        older_next  = older_reg;
        newer_next  = newer_reg;
        lag_next    = lag_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        strong_next = strong_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        max_next    = max_reg;

        if (cmd.load_out)
        begin
            older_next  = '0;
            newer_next  = '0;
            lag_next    = '0;
            first_next  = '0;
            last_next   = '0;
            strong_next = '0;
            count_next  = '0;
            sum_next    = '0;
            max_next    = '0;
        end
        else if (cmd.take_item)
        begin
            older_next = newer_reg;
            newer_next = in_data.corr_value;
            if (lag_reg < LAG_LAST)
            begin
                lag_next = lag_reg + 1'b1;
            end
            if (is_peak)
            begin
                if (newer_reg > $signed({1'b0, max_reg}))
                begin
                    max_next = newer_reg[MAX_W-1:0];
                end
                // Saturate the sum on signed overflow of the narrow range.
                if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                begin
                    sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                               : {1'b0, {(SUM_W-1){1'b1}}};
                end
                else
                begin
                    sum_next = sum_wide[SUM_W-1:0];
                end
                if (count_reg < COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (is_strong)
                begin
                    if (strong_reg == '0)
                    begin
                        first_next = middle_lag;
                    end
                    last_next = middle_lag;
                    if (strong_reg < COUNT_MAX)
                    begin
                        strong_next = strong_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Operands of the shared divider: magnitude of the sum over the peak
    // count, then the strong peak span over the strong count less one.
    always_comb
    begin
        sum_neg = sum_reg[SUM_W-1];
        sum_mag = sum_neg ? (~sum_reg + 1'b1) : sum_reg;
        span    = last_reg - first_reg;
        if (cmd.div_sel_period)
        begin
            div_dividend = {{(SUM_W-LAG_W){1'b0}}, span};
            div_divisor  = strong_reg - 1'b1;
        end
        else
        begin
            div_dividend = sum_mag;
            div_divisor  = count_reg;
        end
    end

    acpe_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        if (sum_neg)
        begin
            if (div_quotient > SUM_W'(32768))
            begin
                avg_value = AVG_NEG_MAX;
            end
            else
            begin
                avg_value = -$signed(div_quotient[VALUE_W-1:0]);
            end
        end
        else
        begin
            if (div_quotient > SUM_W'(32767))
            begin
                avg_value = AVG_POS_MAX;
            end
            else
            begin
                avg_value = $signed(div_quotient[VALUE_W-1:0]);
            end
        end
        per_value = (div_quotient > SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                       : div_quotient[COUNT_W-1:0];
        have_peaks  = count_reg != '0;
        have_period = strong_reg > COUNT_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg     <= BOUND_RESET;
            older_reg     <= '0;
            newer_reg     <= '0;
            lag_reg       <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            strong_reg    <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                bound_reg <= cfg_write_data;
            end
            older_reg     <= older_next;
            newer_reg     <= newer_next;
            lag_reg       <= lag_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            strong_reg    <= strong_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_avg)
        begin
            avg_reg <= avg_value;
        end
        if (cmd.capture_period)
        begin
            per_reg <= per_value;
        end
        if (cmd.load_out)
        begin
            out_data_reg.period            <= have_period ? per_reg : '0;
            out_data_reg.period_valid      <= have_period;
            out_data_reg.average_peak      <= have_peaks ? avg_reg : '0;
            out_data_reg.average_valid     <= have_peaks;
            out_data_reg.highest_peak      <= max_reg;
            out_data_reg.peak_count        <= count_reg;
            out_data_reg.strong_peak_count <= strong_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

// File: sv/acpe_controller.sv
// Controller: sequences lag intake, the two divisions and the result load.
// Depends on acpe_pkg.
module acpe_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    input  logic              out_ready,
    input  acpe_pkg::status_t status,
    output acpe_pkg::cmd_t    cmd
);
    import acpe_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;

        unique case (state_reg)
            ST_ACCUM:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_AVG_START;
                end
            end
            ST_AVG_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.capture_avg = 1'b1;
                    state_next      = ST_PER_START;
                end
            end
            ST_PER_START:
            begin
                cmd.div_start      = 1'b1;
                cmd.div_sel_period = 1'b1;
                state_next         = ST_PER_WAIT;
            end
            ST_PER_WAIT:
            begin
                cmd.div_sel_period = 1'b1;
                if (status.div_done)
                begin
                    cmd.capture_period = 1'b1;
                    state_next         = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                // The previous result must have left the output register, or be taken in this cycle.
                if (!status.out_full || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

// File: sv/autocorrelation_peak_period_estimator_top.sv
// Autocorrelation peak period estimator: takes one lag value per transaction
// and reports one result after the transaction marked last_lag. While a
// sequence streams in, a lag is accepted every cycle. After the last lag the
// input stalls while the shared bit-serial divider, one iteration per dividend
// bit, runs first for the average peak and then for the period, with sequencing
// states around each run; the stall grows only when the previous result has
// not been taken yet. The result then goes to an output register, so the next
// sequence may start while that result still waits to be taken. There is no
// clearing pass.
// Depends on acpe_pkg, acpe_controller and acpe_datapath.
module autocorrelation_peak_period_estimator_top #(
    parameter int MAX_LAGS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  acpe_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output acpe_pkg::out_item_t                 out_data,
    input  logic                                cfg_write_en,
    input  logic signed [acpe_pkg::VALUE_W-1:0] cfg_write_data
);
    import acpe_pkg::*;

    cmd_t    cmd;
    status_t status;

    acpe_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_lag),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    acpe_datapath #(
        .MAX_LAGS (MAX_LAGS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_data        (in_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_data       (out_data)
    );

endmodule

// File: verif/acpe_report_checker.sv
`timescale 1ns / 1ps
// Checker for the autocorrelation peak period estimator: tracks peaks lag by lag,
// predicts the report of every sequence and compares it with the block's output.
// Depends on acpe_pkg for the transaction types, widths and the bound reset value.
module acpe_report_checker #(
    parameter int LAG_LIMIT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  acpe_pkg::in_item_t                  in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  acpe_pkg::out_item_t                 out_data,
    input  logic                                cfg_write_en,
    input  logic signed [acpe_pkg::VALUE_W-1:0] cfg_write_data,
    output int                                  mismatch_count,
    output int                                  outstanding
);
    import acpe_pkg::*;

    localparam longint SUM_HI = 64'sd16777215;
    localparam longint SUM_LO = -64'sd16777216;

    logic signed [VALUE_W-1:0] bound_q;
    logic signed [VALUE_W-1:0] older_q;
    logic signed [VALUE_W-1:0] newer_q;
    logic [COUNT_W-1:0]        lag_q;
    logic [COUNT_W-1:0]        first_strong_q;
    logic [COUNT_W-1:0]        last_strong_q;
    logic [COUNT_W-1:0]        strong_q;
    logic [COUNT_W-1:0]        peaks_q;
    logic signed [SUM_W-1:0]   sum_q;
    logic [MAX_W-1:0]          highest_q;

    out_item_t expected_reports[$];

    task automatic clear_sequence_state();
        older_q        = '0;
        newer_q        = '0;
        lag_q          = '0;
        first_strong_q = '0;
        last_strong_q  = '0;
        strong_q       = '0;
        peaks_q        = '0;
        sum_q          = '0;
        highest_q      = '0;
    endtask

    task automatic record_peak(input int v, input int lag);
        longint total;
        logic [31:0] lag_bits;
        total = longint'(sum_q) + v;
        lag_bits = lag;
        if (v > int'(highest_q))
            highest_q = v[MAX_W-1:0];
        if (total > SUM_HI)
            total = SUM_HI;
        else if (total < SUM_LO)
            total = SUM_LO;
        sum_q = total[SUM_W-1:0];
        if (peaks_q != COUNT_MAX)
            peaks_q = peaks_q + 1'b1;
        if (v > int'(bound_q))
        begin
            if (strong_q == '0)
                first_strong_q = lag_bits[COUNT_W-1:0];
            last_strong_q = lag_bits[COUNT_W-1:0];
            if (strong_q != COUNT_MAX)
                strong_q = strong_q + 1'b1;
        end
    endtask

    // Advances the peak tracker by one lag and queues a report on the last lag.
    task automatic track_lag(input in_item_t item);
        int        cur;
        int        older;
        int        newer;
        int        span;
        int        spacing;
        longint    quotient;
        out_item_t report;
        cur   = int'(item.corr_value);
        older = int'(older_q);
        newer = int'(newer_q);
        // The middle value is judged once both of its neighbors are known.
        if (lag_q >= 2 && older < newer && newer > cur)
            record_peak(newer, int'(lag_q) - 1);
        older_q = newer_q;
        newer_q = item.corr_value;
        if (int'(lag_q) < LAG_LIMIT - 1)
            lag_q = lag_q + 1'b1;
        if (item.last_lag)
        begin
            report = '0;
            if (peaks_q != '0)
            begin
                quotient = longint'(sum_q) / longint'(peaks_q);
                if (quotient > 32767)
                    quotient = 32767;
                else if (quotient < -32768)
                    quotient = -32768;
                report.average_peak  = quotient[VALUE_W-1:0];
                report.average_valid = 1'b1;
            end
            if (strong_q > 1)
            begin
                span    = int'(last_strong_q) - int'(first_strong_q);
                spacing = span / (int'(strong_q) - 1);
                if (spacing > int'(COUNT_MAX))
                    spacing = int'(COUNT_MAX);
                report.period       = spacing[COUNT_W-1:0];
                report.period_valid = 1'b1;
            end
            report.highest_peak      = highest_q;
            report.peak_count        = peaks_q;
            report.strong_peak_count = strong_q;
            expected_reports.insert(expected_reports.size(), report);
            clear_sequence_state();
        end
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            bound_q = BOUND_RESET;
            clear_sequence_state();
            expected_reports.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: report with no sequence pending, expected none, got %p",
                             $time, out_data);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("period", int'(want.period), int'(out_data.period));
                    compare_field("period_valid", int'(want.period_valid),
                                  int'(out_data.period_valid));
                    compare_field("average_peak", int'(want.average_peak),
                                  int'(out_data.average_peak));
                    compare_field("average_valid", int'(want.average_valid),
                                  int'(out_data.average_valid));
                    compare_field("highest_peak", int'(want.highest_peak),
                                  int'(out_data.highest_peak));
                    compare_field("peak_count", int'(want.peak_count),
                                  int'(out_data.peak_count));
                    compare_field("strong_peak_count", int'(want.strong_peak_count),
                                  int'(out_data.strong_peak_count));
                end
            end
            // A lag taken at the same edge as a bound write still sees the old bound.
            if (in_valid && in_ready)
                track_lag(in_data);
            if (cfg_write_en)
                bound_q = cfg_write_data;
        end
        outstanding = expected_reports.size();
    end

endmodule

// File: verif/autocorrelation_peak_period_estimator_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the autocorrelation peak period estimator: drives lag
// sequences and bound settings, and gives the verdict from acpe_report_checker.
// Depends on acpe_pkg, acpe_report_checker and the block's top level.
module autocorrelation_peak_period_estimator_top_test;
    import acpe_pkg::*;

    localparam int MAX_LAGS      = 1024;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_LAGS    = 80;
    localparam int LONG_LAGS     = 1100;

    typedef enum int {
        STYLE_SPREAD,
        STYLE_PERIODIC,
        STYLE_COARSE,
        STYLE_ALTERNATE
    } lag_style_t;

    // Peaks of full scale, a plateau, a peak equal to the bound and a negative peak.
    localparam logic signed [VALUE_W-1:0] MIXED_LAGS [15] = '{
        -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 16'sd100,
        16'sd200, 16'sd200, 16'sd100, 16'sd8192, 16'sd0,
        16'sd8193, 16'sd0, -16'sd300, -16'sd100, -16'sd200
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    in_item_t                  in_data;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_write_en;
    logic signed [VALUE_W-1:0] cfg_write_data;
    logic                      steady = 1'b0;
    int                        mismatch_count;
    int                        outstanding;
    int                        lags_sent = 0;
    int                        seqs_sent = 0;
    int                        bounds_written = 0;

    autocorrelation_peak_period_estimator_top #(
        .MAX_LAGS(MAX_LAGS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    acpe_report_checker #(
        .LAG_LIMIT(MAX_LAGS)
    ) report_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 28);

    initial
    begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_lag(input logic signed [VALUE_W-1:0] v, input logic last);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{corr_value: v, last_lag: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        lags_sent++;
        if (last)
            seqs_sent++;
    endtask

    task automatic send_sequence(input int len, input lag_style_t style);
        int                        spacing;
        int                        offset;
        int                        peak_floor;
        int                        pos;
        logic signed [VALUE_W-1:0] v;
        spacing    = $urandom_range(2, 12);
        offset     = $urandom_range(0, spacing - 1);
        peak_floor = $urandom_range(1, 16384);
        for (pos = 0; pos < len; pos++)
        begin
            case (style)
                STYLE_SPREAD:
                    v = 16'(int'($urandom_range(0, 32768)) - 16384);
                STYLE_PERIODIC:
                    // Peaks on a fixed spacing, every other lag strictly below them.
                    if (pos % spacing == offset)
                        v = 16'(int'($urandom_range(peak_floor, 16384)));
                    else
                        v = 16'(int'($urandom_range(0, peak_floor - 1 + 16384)) - 16384);
                STYLE_COARSE:
                    v = 16'((int'($urandom_range(0, 4)) - 2) * 8192);
                default:
                    v = (pos % 2 == 1) ? 16'sd32767 : 16'sd0;
            endcase
            send_lag(v, pos == len - 1);
        end
    endtask

    task automatic wait_reports();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_bound(input logic signed [VALUE_W-1:0] v);
        wait_reports();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        bounds_written++;
    endtask

    initial
    begin
        int                        phase;
        int                        phase_lags;
        int                        len;
        int                        guard;
        int                        i;
        bit                        paused;
        logic signed [VALUE_W-1:0] bound;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        paused         = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sequences under the reset bound: one lag, two lags, the mixed
        // case, and a sequence whose largest value sits on its last lag.
        send_lag(16'sd0, 1'b1);
        send_lag(16'sd16384, 1'b0);
        send_lag(-16'sd16384, 1'b1);
        for (i = 0; i < 15; i++)
            send_lag(MIXED_LAGS[i], i == 14);
        send_lag(16'sd0, 1'b0);
        send_lag(16'sd100, 1'b0);
        send_lag(16'sd9000, 1'b1);

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       bound = 16'sd16384;
                1:       bound = -16'sd16384;
                2:       bound = 16'sd0;
                default: bound = 16'(int'($urandom_range(0, 32768)) - 16384);
            endcase
            write_bound(bound);
            steady <= (phase == 3);
            phase_lags = 0;
            while (phase_lags < PHASE_LAGS)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(100, 200);
                else
                    len = $urandom_range(4, 40);
                send_sequence(len, lag_style_t'($urandom_range(0, 2)));
                phase_lags += len;
                if (phase == 2 && !paused && phase_lags > PHASE_LAGS / 2)
                begin
                    wait_reports();
                    paused = 1'b1;
                end
            end
        end

        // One sequence past the lag limit with a large peak on every other lag,
        // so the lag position freezes and the peak sum saturates.
        write_bound(16'sd0);
        steady <= 1'b1;
        send_sequence(LONG_LAGS, STYLE_ALTERNATE);
        steady <= 1'b0;

        in_valid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d lag transactions in %0d sequences over %0d bound writes,",
                 lags_sent, seqs_sent, bounds_written);
        $display("with short, plateau, periodic, saturating and over-length sequences.");
        if (mismatch_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
